FILE: design/samm_pkg.sv
`default_nettype none

package samm_pkg;

   // Capacity of the sorted store and derived widths
   localparam int MAX_ITEMS = 64;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int VAL_W     = 32;

   // Depth of the queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // One accepted word as it travels through the queue
   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    last;
   } samm_entry_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_READ,
      ST_EMIT
   } samm_state_type;

endpackage

`default_nettype wire

FILE: design/samm_front.sv
`default_nettype none

module samm_front
   import samm_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [31:0]    req_tdata,   // [31:0] value
   input  wire logic           req_tlast,   // last_in
   output samm_entry_type      pop_entry,
   output logic                pop_valid,
   input  wire logic           pop_ready
);

   samm_entry_type           q_ff [QDEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]          fill_ff, fill_in;
   logic                     push;
   logic                     pop;
   samm_entry_type           push_entry;

   // Classify the incoming word: value plus end-of-set mark
   assign push_entry.value = $signed(req_tdata[VAL_W-1:0]);
   assign push_entry.last  = req_tlast;

   assign req_tready = (fill_ff != (QPTR_W+1)'(QDEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = q_ff[rd_ptr_ff];

   assign push = req_tvalid && req_tready;
   assign pop  = pop_valid && pop_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Hold queued words
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: design/samm_back.sv
`default_nettype none

module samm_back
   import samm_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire samm_entry_type pop_entry,
   input  wire logic           pop_valid,
   output logic                pop_ready,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [31:0]         rsp_tdata,   // [31:0] out_value
   output logic                rsp_tlast,   // last_out
   output logic                rsp_tuser    // overflowed
);

   samm_state_type           state_ff, state_in;

   logic signed [VAL_W-1:0]  store_ff [MAX_ITEMS];
   logic signed [VAL_W-1:0]  rdata_ff;
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic signed [VAL_W-1:0]  mem_wdata;
   logic [IDX_W-1:0]         rd_addr;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     ovf_ff, ovf_in;
   logic signed [VAL_W-1:0]  v_ff, v_in;
   logic                     last_ff, last_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [IDX_W-1:0]         lo_ff, lo_in;
   logic [IDX_W-1:0]         hm_ff, hm_in;
   logic                     odd_ff, odd_in;
   logic [CNT_W-1:0]         left_ff, left_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0]  rsp_value_ff;
   logic                     rsp_last_ff;
   logic                     rsp_ovf_ff;
   logic                     rsp_load;
   logic                     out_free;
   logic                     full;
   logic                     empty;
   logic                     bigger;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign full     = (count_ff == CNT_W'(MAX_ITEMS));
   assign empty    = (count_ff == '0);
   assign bigger   = (rdata_ff > v_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               if (full || empty) begin
                  state_in = pop_entry.last ? ST_READ : ST_IDLE;
               end else begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (bigger) begin
               state_in = (pos_ff == IDX_W'(1)) ? ST_PLACE : ST_SHIFT;
            end else begin
               state_in = last_ff ? ST_READ : ST_IDLE;
            end
         end
         ST_PLACE: begin
            state_in = last_ff ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && left_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath control: insertion shifts, store writes, readout walk
   always_comb begin
      pop_ready = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = v_ff;
      rd_addr   = lo_ff;
      rsp_load  = 1'b0;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      v_in      = v_ff;
      last_in   = last_ff;
      pos_in    = pos_ff;
      lo_in     = lo_ff;
      hm_in     = hm_ff;
      odd_in    = odd_ff;
      left_in   = left_ff;
      case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               if (full) begin
                  // Drop the word, keep the set
                  ovf_in = 1'b1;
                  if (pop_entry.last) begin
                     lo_in   = '0;
                     hm_in   = IDX_W'(count_ff - 1'b1);
                     odd_in  = 1'b0;
                     left_in = count_ff;
                  end
               end else if (empty) begin
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = pop_entry.value;
                  count_in  = CNT_W'(1);
                  if (pop_entry.last) begin
                     lo_in   = '0;
                     hm_in   = '0;
                     odd_in  = 1'b0;
                     left_in = CNT_W'(1);
                  end
               end else begin
                  // Start scanning down from the top entry
                  v_in    = pop_entry.value;
                  last_in = pop_entry.last;
                  pos_in  = count_ff[IDX_W-1:0];
                  rd_addr = count_ff[IDX_W-1:0] - 1'b1;
               end
            end
         end
         ST_SHIFT: begin
            mem_we = 1'b1;
            if (bigger) begin
               // Move the larger entry up one place
               mem_wdata = rdata_ff;
               pos_in    = pos_ff - 1'b1;
               rd_addr   = pos_ff - IDX_W'(2);
            end else begin
               count_in = count_ff + 1'b1;
               if (last_ff) begin
                  lo_in   = '0;
                  hm_in   = count_ff[IDX_W-1:0];
                  odd_in  = 1'b0;
                  left_in = count_ff + 1'b1;
               end
            end
         end
         ST_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            count_in  = count_ff + 1'b1;
            if (last_ff) begin
               lo_in   = '0;
               hm_in   = count_ff[IDX_W-1:0];
               odd_in  = 1'b0;
               left_in = count_ff + 1'b1;
            end
         end
         ST_READ: begin
            rd_addr = lo_ff;
         end
         ST_EMIT: begin
            rd_addr = odd_ff ? hm_ff : lo_ff;
            if (out_free) begin
               // Emit current end, fetch the opposite end
               rsp_load = 1'b1;
               rd_addr  = odd_ff ? lo_ff : hm_ff;
               odd_in   = !odd_ff;
               left_in  = left_ff - 1'b1;
               if (odd_ff) begin
                  hm_in = hm_ff - 1'b1;
               end else begin
                  lo_in = lo_ff + 1'b1;
               end
               if (left_ff == CNT_W'(1)) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      last_ff <= last_in;
      pos_ff  <= pos_in;
      lo_ff   <= lo_in;
      hm_ff   <= hm_in;
      odd_ff  <= odd_in;
      left_ff <= left_in;
      if (rsp_load) begin
         rsp_value_ff <= rdata_ff;
         rsp_last_ff  <= (left_ff == CNT_W'(1));
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   // Sorted store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= store_ff[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

`default_nettype wire

FILE: design/sort_alternate_min_max_core.sv
`default_nettype none

// Collects signed 32-bit words into an ascending store of up to 64 entries
// and, on the word marked tlast, streams them out as smallest, largest,
// second smallest, second largest and so on (median last for an odd count),
// then starts a fresh set. Words that arrive with the store full are dropped
// and every result of that set carries tuser high. A four-word queue takes
// input while the back end works. A word that opens a set is written
// straight in; any other kept word moves each stored entry larger than
// it up one place, one entry per cycle through the store's single write
// port. After the end-of-set word, results leave at one per cycle while
// rsp_tready stays high.
module sort_alternate_min_max_core
   import samm_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [31:0]    req_tdata,   // [31:0] value
   input  wire logic           req_tlast,   // last_in
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [31:0]         rsp_tdata,   // [31:0] out_value
   output logic                rsp_tlast,   // last_out
   output logic                rsp_tuser    // [0] overflowed
);

   samm_entry_type   pop_entry;
   logic             pop_valid;
   logic             pop_ready;

   samm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   samm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import samm_pkg::*;

   localparam int RSP_HOLD_CYCLES = 600;
   localparam int RANDOM_WORDS    = 110;
   localparam int DRAIN_CYCLES    = 100;
   localparam int IDLE_PERCENT    = 21;
   localparam int MAX_PRINTS      = 50;

   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   typedef enum int {
      SHAPE_RANDOM,
      SHAPE_RISING,
      SHAPE_FALLING
   } set_shape_type;

   // One result word as the block should emit it
   typedef struct {
      logic signed [31:0] value;
      logic               last;
      logic               ovf;
   } minmax_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic        req_tlast = 1'b0;  // last_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] out_value
   logic        rsp_tlast;        // last_out
   logic        rsp_tuser;        // [0] overflowed

   // Shadow of the sorted store and the expected output stream
   logic signed [31:0] sorted_vals[$];
   bit                 set_overflow = 1'b0;
   minmax_word_type    expected_words[$];

   int  mismatch_count = 0;
   int  words_sent = 0;
   bit  no_idle = 1'b0;
   bit  rsp_hold = 1'b0;
   int  hold_cycles = 0;

   sort_alternate_min_max_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTS)
         $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Insert one word in ascending order, or flag it as dropped when full
   function automatic void store_value(input logic signed [31:0] v);
      int pos;
      if (sorted_vals.size() >= MAX_ITEMS) begin
         set_overflow = 1'b1;
         return;
      end
      pos = sorted_vals.size();
      while (pos > 0 && sorted_vals[pos-1] > v)
         pos--;
      sorted_vals.insert(pos, v);
   endfunction

   // Queue the set as min, max, next min, next max ... then clear it
   function automatic void emit_min_max();
      int              lo;
      int              hi;
      int              n;
      minmax_word_type w;
      n  = sorted_vals.size();
      lo = 0;
      hi = n;
      for (int k = 0; k < n; k++) begin
         if (k % 2 == 0) begin
            w.value = sorted_vals[lo];
            lo++;
         end else begin
            hi--;
            w.value = sorted_vals[hi];
         end
         w.last = (k == n - 1);
         w.ovf  = set_overflow;
         expected_words.push_back(w);
      end
      sorted_vals.delete();
      set_overflow = 1'b0;
   endfunction

   // Check each result word, then feed each accepted input word to the shadow
   always @(posedge clock) begin : scoreboard
      minmax_word_type exp_w;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h", rsp_tdata));
            end else begin
               exp_w = expected_words.pop_front();
               if (rsp_tdata !== exp_w.value)
                  report_mismatch($sformatf("out_value %h, want %h", rsp_tdata, exp_w.value));
               if (rsp_tlast !== exp_w.last)
                  report_mismatch($sformatf("last_out %b, want %b", rsp_tlast, exp_w.last));
               if (rsp_tuser !== exp_w.ovf)
                  report_mismatch($sformatf("overflowed %b, want %b", rsp_tuser, exp_w.ovf));
            end
         end
         if (req_tvalid && req_tready) begin
            store_value(req_tdata);
            if (req_tlast)
               emit_min_max();
         end
      end
   end

   // Result side: random idling, steady stretches, and one long hold-off
   always @(posedge clock) begin
      if (rsp_hold && hold_cycles < RSP_HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
      end else begin
         if (!rsp_hold)
            hold_cycles <= 0;
         rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Offer one word, with an occasional gap ahead of it, and hold until taken
   task automatic send_word(input logic signed [31:0] v, input bit last);
      int gap;
      gap = 0;
      if (!no_idle && $urandom_range(99) < IDLE_PERCENT)
         gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      words_sent++;
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(3))
         0, 1: pick_value = $urandom;
         2: pick_value = int'($urandom_range(15)) - 8;
         default: begin
            case ($urandom_range(3))
               0: pick_value = VAL_MIN;
               1: pick_value = VAL_MAX;
               2: pick_value = 0;
               default: pick_value = -1;
            endcase
         end
      endcase
   endfunction

   task automatic send_set(input int count, input set_shape_type shape);
      logic signed [31:0] base;
      logic signed [31:0] step;
      logic signed [31:0] v;
      base = $urandom;
      step = $urandom_range(1, 1000);
      for (int i = 0; i < count; i++) begin
         case (shape)
            SHAPE_RISING:  v = base + i * step;
            SHAPE_FALLING: v = base - i * step;
            default:       v = pick_value();
         endcase
         send_word(v, i == count - 1);
      end
   endtask

   // Drop valid and wait for every outstanding result
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_extremes();
      send_word(VAL_MAX, 1'b0);
      send_word(VAL_MIN, 1'b0);
      send_word(0, 1'b0);
      send_word(-1, 1'b0);
      send_word(1, 1'b1);
      send_word(VAL_MIN, 1'b0);
      send_word(VAL_MAX, 1'b1);
   endtask

   task automatic test_duplicates();
      send_word(5, 1'b0);
      send_word(-5, 1'b0);
      send_word(5, 1'b0);
      send_word(5, 1'b0);
      send_word(-5, 1'b0);
      send_word(5, 1'b1);
      send_word(0, 1'b0);
      send_word(0, 1'b0);
      send_word(0, 1'b1);
   endtask

   task automatic test_single_word();
      send_word(VAL_MIN, 1'b1);
      send_word(VAL_MAX, 1'b1);
   endtask

   // Full store, last word dropped, and several dropped words
   task automatic test_capacity();
      for (int i = 0; i < MAX_ITEMS; i++)
         send_word(VAL_MAX - i, i == MAX_ITEMS - 1);
      send_set(MAX_ITEMS + 1, SHAPE_RANDOM);
      send_set(MAX_ITEMS + 4, SHAPE_FALLING);
   endtask

   // Hold results off so the input queue fills while words keep coming
   task automatic test_input_stall();
      rsp_hold = 1'b1;
      send_set(12, SHAPE_FALLING);
      repeat (4) send_set(2, SHAPE_RANDOM);
      send_set(5, SHAPE_RISING);
      req_tvalid <= 1'b0;
      while (hold_cycles < RSP_HOLD_CYCLES)
         @(posedge clock);
      rsp_hold = 1'b0;
   endtask

   task automatic test_drain_pause();
      send_set(6, SHAPE_RANDOM);
      pause_until_drained();
      send_set(3, SHAPE_RISING);
      pause_until_drained();
   endtask

   task automatic test_random_sets();
      int            first;
      int            r;
      int            count;
      set_shape_type shape;
      first = words_sent;
      while (words_sent - first < RANDOM_WORDS) begin
         no_idle = (words_sent - first >= 20) && (words_sent - first < 90);
         r = $urandom_range(99);
         if (r < 85)
            count = $urandom_range(1, 10);
         else if (r < 95)
            count = $urandom_range(11, 40);
         else
            count = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6);
         if (count > RANDOM_WORDS - (words_sent - first))
            count = RANDOM_WORDS - (words_sent - first);
         case ($urandom_range(3))
            0: shape = SHAPE_RISING;
            1: shape = SHAPE_FALLING;
            default: shape = SHAPE_RANDOM;
         endcase
         send_set(count, shape);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_duplicates();
      test_single_word();
      test_capacity();
      test_input_stall();
      test_drain_pause();
      test_random_sets();
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[sort_alternate_min_max_core] OK");
      else
         $display("[sort_alternate_min_max_core] ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("[sort_alternate_min_max_core] ERROR");
      $finish;
   end

endmodule
